>>> design/lto_pkg.sv
// Shared types, constants and the sine table generator for the sine LFO tremolo.
// No dependencies; all other design files refer to it by scoped names.

package lto_pkg;

	localparam int unsigned SAMPLE_W        = 16;
	localparam int unsigned PHASE_W         = 16;
	localparam int unsigned STEP_W          = 15;
	localparam int unsigned ATT_W           = 16;
	localparam int unsigned CFG_IDX_W       = 2;
	localparam int unsigned SINE_W          = 15;
	localparam int unsigned SINE_BITS_DEF   = 10;
	localparam int unsigned MUL_A_W         = 18;
	localparam int unsigned MUL_B_W         = 34;
	localparam int unsigned MUL_P_W         = MUL_A_W + MUL_B_W;

	localparam logic [ATT_W-1:0] MAX_ATT_RESET = 16'd13107;
	// 0.99 in unsigned Q0.16
	localparam logic [15:0]      DEPTH_SCALE   = 16'd64881;
	// pi/2 in Q2.30
	localparam logic [63:0]      HALF_PI_Q30   = 64'd1686629713;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP  = 2'd0,
		CFG_START_PHASE = 2'd1,
		CFG_MAX_ATT     = 2'd2
	} cfg_idx_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MDEP  = 7'b0000010,
		ST_DEP   = 7'b0000100,
		ST_MGAIN = 7'b0001000,
		ST_GAIN  = 7'b0010000,
		ST_MOUT  = 7'b0100000,
		ST_RND   = 7'b1000000
	} state_t;

	// One quarter-wave table entry: Taylor series of sin through x^17 in Q2.30,
	// scaled to 32767 and rounded. Evaluated at elaboration only.
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
			input int unsigned bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		x    = (HALF_PI_Q30 * 64'(k)) >> (bits - 2);
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd272;
		sum  = sum + term;
		v    = (sum * 64'd32767 + 64'd536870912) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[SINE_W-1:0];
	endfunction

endpackage

>>> design/sine_lfo_tremolo.sv
// Sine LFO tremolo top level: sequencer, phase accumulator, config registers.
// Depends on lto_pkg, lto_sine_rom and lto_mul.
//
// Usage:
//   Input channel (in_valid / in_stall, sample_in, restart): one signed Q1.15
//   sample per word. A word is taken when in_valid is high and in_stall low.
//   Output channel (out_valid / out_stall, sample_out): one rounded Q1.15
//   sample per input word, in order.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 is
//   phase_step, 1 start_phase, 2 max_attenuation; other indexes are dropped.
//   cfg_ready is always high. Write only while no sample is in flight.
// Timing:
//   Each sample runs from acceptance to out_valid through five steps of a
//   single shared 18x34 multiplier sequence (depth, gain, product) plus the
//   rounding step. in_stall is high during those steps and the next word is
//   taken only in the idle state that follows, so words do not overlap.
//   The sine table read overlaps the first product.
//   A finished word waits in the output register while the next one is taken;
//   if the receiver stalls, the sequencer holds in its last step until the
//   output register frees up.
// Reset:
//   arst_n clears the phase to 0, phase_step and start_phase to 0 and
//   max_attenuation to 13107; the block is idle and ready straight away.

module sine_lfo_tremolo #(
	parameter int unsigned SINE_TABLE_BITS = lto_pkg::SINE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [lto_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [lto_pkg::SAMPLE_W-1:0]  sample_out,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lto_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [31:0]                          cfg_data
);

	localparam int unsigned ADDR_W  = SINE_TABLE_BITS - 1;
	localparam int unsigned POS_W   = SINE_TABLE_BITS - 2;
	localparam int unsigned QUARTER = 2 ** POS_W;
	localparam int unsigned PH_W    = lto_pkg::PHASE_W;
	localparam int unsigned A_W     = lto_pkg::MUL_A_W;
	localparam int unsigned B_W     = lto_pkg::MUL_B_W;
	localparam int unsigned P_W     = lto_pkg::MUL_P_W;

	lto_pkg::state_t                      state_q;
	logic [lto_pkg::STEP_W-1:0]           phase_step_q;
	logic [PH_W-1:0]                      start_phase_q;
	logic [lto_pkg::ATT_W-1:0]            max_att_q;
	logic [PH_W-1:0]                      phase_q;
	logic [PH_W-1:0]                      cur_phase_q;
	logic signed [lto_pkg::SAMPLE_W-1:0]  x_q;
	logic [15:0]                          depth_q;
	logic [31:0]                          gain_q;
	logic                                 out_valid_q;
	logic signed [lto_pkg::SAMPLE_W-1:0]  sample_out_q;

	logic                                 in_acc;
	logic                                 out_free;
	logic [PH_W-1:0]                      phase_use;
	logic [SINE_TABLE_BITS-1:0]           tab_idx;
	logic [POS_W-1:0]                     tab_pos;
	logic [ADDR_W-1:0]                    rom_addr;
	logic                                 sine_neg;
	logic [lto_pkg::SINE_W-1:0]           sine_mag;
	logic signed [A_W-1:0]                sine_val;
	logic signed [A_W-1:0]                mul_a;
	logic signed [B_W-1:0]                mul_b;
	logic                                 mul_en;
	logic signed [P_W-1:0]                mul_p;
	logic [47:0]                          rounded;

	assign in_stall  = (state_q != lto_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign phase_use = restart ? start_phase_q : phase_q;

	// Split the phase into quadrant and table position
	assign tab_idx  = cur_phase_q[PH_W-1 -: SINE_TABLE_BITS];
	assign tab_pos  = tab_idx[POS_W-1:0];
	assign sine_neg = tab_idx[SINE_TABLE_BITS-1];
	assign rom_addr = tab_idx[SINE_TABLE_BITS-2] ?
		(ADDR_W'(QUARTER) - {1'b0, tab_pos}) : {1'b0, tab_pos};

	lto_sine_rom #(
		.TABLE_BITS (SINE_TABLE_BITS)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (sine_mag)
	);

	assign sine_val = sine_neg ? -$signed({3'b000, sine_mag}) : $signed({3'b000, sine_mag});

	// Pick the multiplier operands for the current step
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			lto_pkg::ST_MDEP: begin
				mul_en = 1'b1;
				mul_a  = $signed({1'b0, 17'h10000 - {1'b0, max_att_q}});
				mul_b  = $signed(B_W'(lto_pkg::DEPTH_SCALE));
			end
			lto_pkg::ST_MGAIN: begin
				mul_en = 1'b1;
				mul_a  = sine_val;
				mul_b  = $signed(B_W'(depth_q));
			end
			lto_pkg::ST_MOUT: begin
				mul_en = 1'b1;
				mul_a  = A_W'(x_q);
				mul_b  = $signed(B_W'(gain_q));
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	lto_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Round half up and drop the 32 fraction bits
	assign rounded = mul_p[47:0] + 48'h0000_8000_0000;

	// Sequencer, phase accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lto_pkg::ST_IDLE;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the result as the rounding step ends, drop it once taken
			if (state_q == lto_pkg::ST_RND && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				lto_pkg::ST_IDLE: begin
					if (in_acc) begin
						phase_q <= phase_use + PH_W'(phase_step_q);
						state_q <= lto_pkg::ST_MDEP;
					end
				end
				lto_pkg::ST_MDEP:  state_q <= lto_pkg::ST_DEP;
				lto_pkg::ST_DEP:   state_q <= lto_pkg::ST_MGAIN;
				lto_pkg::ST_MGAIN: state_q <= lto_pkg::ST_GAIN;
				lto_pkg::ST_GAIN:  state_q <= lto_pkg::ST_MOUT;
				lto_pkg::ST_MOUT:  state_q <= lto_pkg::ST_RND;
				lto_pkg::ST_RND: begin
					if (out_free) begin
						state_q <= lto_pkg::ST_IDLE;
					end
				end
				default: state_q <= lto_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q         <= sample_in;
			cur_phase_q <= phase_use;
		end
		if (state_q == lto_pkg::ST_DEP) begin
			depth_q <= 16'((mul_p[33:0] + 34'd32768) >> 16);
		end
		if (state_q == lto_pkg::ST_GAIN) begin
			gain_q <= {1'b1, max_att_q, 15'b0} + mul_p[31:0];
		end
		if (state_q == lto_pkg::ST_RND && out_free) begin
			sample_out_q <= $signed(rounded[47:32]);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q  <= '0;
			start_phase_q <= '0;
			max_att_q     <= lto_pkg::MAX_ATT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lto_pkg::CFG_PHASE_STEP:  phase_step_q  <= cfg_data[lto_pkg::STEP_W-1:0];
				lto_pkg::CFG_START_PHASE: start_phase_q <= cfg_data[PH_W-1:0];
				lto_pkg::CFG_MAX_ATT:     max_att_q     <= cfg_data[lto_pkg::ATT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// A new word always starts the depth product
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == lto_pkg::ST_MDEP)
		else $error("accepted word did not start the sequence");

	// A result only appears out of the rounding step
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == lto_pkg::ST_RND))
		else $error("result raised outside the rounding step");

	// Phase advances by the step when no restart is asked for
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !restart |=>
			phase_q == PH_W'($past(phase_q) + PH_W'($past(phase_step_q))))
		else $error("phase did not advance by the step");

	// Gain is strictly positive when the final product is issued
	a_gain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lto_pkg::ST_MOUT |-> gain_q != 32'd0)
		else $error("gain collapsed to zero");

endmodule

>>> design/lto_sine_rom.sv
// Quarter-wave sine table with registered read.
// Depends on lto_pkg for the entry generator and the entry width.

module lto_sine_rom #(
	parameter int unsigned TABLE_BITS = lto_pkg::SINE_BITS_DEF
) (
	input  logic                          clk,
	input  logic [TABLE_BITS-2:0]         addr,
	output logic [lto_pkg::SINE_W-1:0]    data
);

	localparam int unsigned DEPTH = (2 ** (TABLE_BITS - 2)) + 1;

	logic [lto_pkg::SINE_W-1:0] entry_w [0:DEPTH-1];
	logic [lto_pkg::SINE_W-1:0] data_q;

	// Build the table from constants
	for (genvar k = 0; k < DEPTH; k++) begin : g_entry
		localparam logic [lto_pkg::SINE_W-1:0] ENTRY = lto_pkg::sine_entry(k, TABLE_BITS);
		assign entry_w[k] = ENTRY;
	end

	// Register the read word
	always_ff @(posedge clk) begin
		data_q <= entry_w[addr];
	end

	assign data = data_q;

endmodule

>>> design/lto_mul.sv
// Shared signed multiplier with registered product, reused for every product step.
// Depends on lto_pkg for operand widths.

module lto_mul (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [lto_pkg::MUL_A_W-1:0]     a,
	input  logic signed [lto_pkg::MUL_B_W-1:0]     b,
	output logic signed [lto_pkg::MUL_P_W-1:0]     p
);

	logic signed [lto_pkg::MUL_P_W-1:0] product_q;

	// Capture the product when the sequencer issues a step
	always_ff @(posedge clk) begin
		if (en) begin
			product_q <= lto_pkg::MUL_P_W'(a) * lto_pkg::MUL_P_W'(b);
		end
	end

	assign p = product_q;

endmodule
